// ----- hw/rtl/bsphv_pkg.sv -----
// ----------------------------------------------------------------------------
// bsphv_pkg
// Types, codes and constant tables for the BSP header validator: payload
// structs, verdict codes, config register indexes, lump element sizes and the
// nibble weights used for the running length remainder.
// ----------------------------------------------------------------------------
package bsphv_pkg;

    // verdict codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_BAD_IDENT   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_NEGATIVE    = 3'd4,
        ST_PAST_END    = 3'd5,
        ST_NOT_WHOLE   = 3'd6
    } status_t;

    // config register indexes
    localparam logic [1:0] REG_FILE_LENGTH    = 2'd0;
    localparam logic [1:0] REG_MAGIC_WORD     = 2'd1;
    localparam logic [1:0] REG_FORMAT_VERSION = 2'd2;

    // bytes 'R','B','S','P' read little-endian
    localparam logic [31:0] MAGIC_RESET   = 32'h5053_4252;
    localparam logic [31:0] VERSION_RESET = 32'd1;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       header_start;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  failed_lump;
        logic [30:0] lump_length;
        logic [7:0]  entry_size;
    } out_item_t;

    // element size of each lump, zero means plain bytes
    function automatic logic [7:0] elem_size(input logic [4:0] lump);
        logic [7:0] es;
        unique case (lump)
            5'd1:    es = 8'd72;
            5'd2:    es = 8'd16;
            5'd3:    es = 8'd36;
            5'd4:    es = 8'd48;
            5'd5:    es = 8'd4;
            5'd6:    es = 8'd4;
            5'd7:    es = 8'd40;
            5'd8:    es = 8'd12;
            5'd9:    es = 8'd12;
            5'd10:   es = 8'd80;
            5'd12:   es = 8'd72;
            5'd13:   es = 8'd148;
            default: es = 8'd0;
        endcase
        return es;
    endfunction

    // 16^nib mod es, for every element size in the table
    function automatic logic [7:0] nib_weight(input logic [7:0] es, input logic [2:0] nib);
        logic [7:0] w;
        w = 8'd0;
        if (nib == 3'd0) begin
            w = 8'd1;
        end else begin
            unique case (es)
                8'd72: begin
                    unique case (nib)
                        3'd1, 3'd4, 3'd7: w = 8'd16;
                        3'd2, 3'd5:       w = 8'd40;
                        default:          w = 8'd64;
                    endcase
                end
                8'd36: begin
                    unique case (nib)
                        3'd1, 3'd4, 3'd7: w = 8'd16;
                        3'd2, 3'd5:       w = 8'd4;
                        default:          w = 8'd28;
                    endcase
                end
                8'd48, 8'd40, 8'd80: w = 8'd16;
                8'd12:               w = 8'd4;
                8'd148: begin
                    unique case (nib)
                        3'd1:    w = 8'd16;
                        3'd2:    w = 8'd108;
                        3'd3:    w = 8'd100;
                        3'd4:    w = 8'd120;
                        3'd5:    w = 8'd144;
                        3'd6:    w = 8'd84;
                        default: w = 8'd12;
                    endcase
                end
                default: w = 8'd0;
            endcase
        end
        return w;
    endfunction

    // reduce a value below 31*es to its remainder, five compare-subtract steps
    function automatic logic [7:0] reduce_mod(input logic [12:0] t, input logic [7:0] es);
        logic [12:0] acc;
        logic [12:0] sub;
        acc = t;
        for (int i = 4; i >= 0; i--) begin
            sub = 13'(es) << i;
            if (acc >= sub) begin
                acc = acc - sub;
            end
        end
        return acc[7:0];
    endfunction

endpackage

// ----- hw/rtl/bsp_header_validator.sv -----
// ----------------------------------------------------------------------------
// bsp_header_validator
// Streaming check of a BSP map header, one byte per transfer, against a
// configured file length, identifier and version.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one header byte per transfer, header_start marks the
//   first byte of a header and restarts the check. m_ channel carries the
//   verdict: at most one per header, on the byte that decides it (ok after
//   the last byte, or the first failure with its lump index, length and
//   element size). bytes after a verdict are dropped until the next start.
//   config port writes file_length, magic_word and format_version; write
//   only while no byte is in flight.
// timing:
//   one byte per cycle sustained while no held verdict blocks the pipeline.
//   a byte sits in the input register, is checked by the combinational
//   pass and its verdict lands in the output register, which drives
//   m_valid and m_data.
// reset:
//   aresetn low clears both pipeline registers, loads config defaults and
//   leaves the checker idle until a header start.
// stalls:
//   while m_ready is low a held verdict blocks the pipeline, and s_ready
//   drops once the input register is also full.
// ----------------------------------------------------------------------------
module bsp_header_validator
    import bsphv_pkg::*;
#(
    parameter int LUMP_COUNT = 18
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);

    localparam int HEADER_BYTES = 8 + 8 * LUMP_COUNT;
    localparam int POS_W        = $clog2(HEADER_BYTES);

    // config registers
    logic [31:0] file_length_reg;
    logic [31:0] magic_word_reg;
    logic [31:0] format_version_reg;

    // input register
    logic        in_vld_reg;
    in_item_t    in_item_reg;

    // header walk state
    logic [POS_W-1:0] pos_reg,     pos_next;
    logic [31:0]      word_reg,    word_next;
    logic [31:0]      offset_reg,  offset_next;
    logic [7:0]       rem_reg,     rem_next;
    logic             verdict_reg, verdict_next;

    // output register
    logic        m_vld_reg;
    out_item_t   m_item_reg;

    logic        adv;
    logic        emit;
    out_item_t   res;

    logic             start;
    logic [7:0]       b;
    logic [POS_W-1:0] pos_eff;
    logic [1:0]       k;
    logic [POS_W-1:0] rel;
    logic [2:0]       lump_byte;
    logic [4:0]       lump;
    logic [7:0]       es;
    logic             in_lumps;
    logic [7:0]       rem_base;
    logic [7:0]       w_lo, w_hi;
    logic [12:0]      rem_sum;
    logic [32:0]      lump_end;

    // byte leaves the input register whenever the output register can take it
    assign adv     = in_vld_reg && (!m_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;
    assign m_valid = m_vld_reg;
    assign m_data  = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg    <= '0;
            magic_word_reg     <= MAGIC_RESET;
            format_version_reg <= VERSION_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FILE_LENGTH:    file_length_reg    <= cfg_wr_data;
                REG_MAGIC_WORD:     magic_word_reg     <= cfg_wr_data;
                REG_FORMAT_VERSION: format_version_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    // single pass over the byte in the input register
    always_comb begin
        start     = in_item_reg.header_start;
        b         = in_item_reg.byte_value;
        pos_eff   = start ? '0 : pos_reg;
        k         = pos_eff[1:0];
        rel       = pos_eff - POS_W'(8);
        lump_byte = rel[2:0];
        lump      = 5'(rel >> 3);
        in_lumps  = (pos_eff >= POS_W'(8));
        es        = elem_size(lump);

        pos_next     = pos_reg;
        word_next    = word_reg;
        offset_next  = offset_reg;
        rem_next     = rem_reg;
        verdict_next = verdict_reg;
        emit         = 1'b0;
        res          = '{status: ST_OK, failed_lump: '0, lump_length: '0, entry_size: '0};

        // byte lands in its lane of the little-endian word
        if (k == 2'd0) begin
            word_next = {24'd0, b};
        end else begin
            word_next = word_reg | ({24'd0, b} << {k, 3'b000});
        end

        // remainder of the length word by the element size, nibble by nibble
        rem_base = (lump_byte == 3'd4 || start) ? 8'd0 : rem_reg;
        w_lo     = nib_weight(es, {k, 1'b0});
        w_hi     = nib_weight(es, {k, 1'b1});
        rem_sum  = 13'(rem_base) + 13'(b[3:0]) * 13'(w_lo) + 13'(b[7:4]) * 13'(w_hi);
        lump_end = {1'b0, offset_reg} + {1'b0, word_next};

        if (start || !verdict_reg) begin
            verdict_next = 1'b0;
            if (start && file_length_reg < 32'(HEADER_BYTES)) begin
                emit       = 1'b1;
                res.status = ST_SHORT;
            end else begin
                if (in_lumps) begin
                    if (lump_byte == 3'd4) begin
                        rem_next = 8'd0;
                    end
                    if (lump_byte >= 3'd4 && es != 8'd0) begin
                        rem_next = reduce_mod(rem_sum, es);
                    end
                    if (lump_byte == 3'd3) begin
                        offset_next = word_next;
                    end
                    if (lump_byte == 3'd7) begin
                        res.failed_lump = lump;
                        res.lump_length = word_next[30:0];
                        res.entry_size  = es;
                        priority if (offset_reg[31] || word_next[31]) begin
                            emit       = 1'b1;
                            res.status = ST_NEGATIVE;
                        end else if (lump_end > {1'b0, file_length_reg}) begin
                            emit       = 1'b1;
                            res.status = ST_PAST_END;
                        end else if (es != 8'd0 && rem_next != 8'd0) begin
                            emit       = 1'b1;
                            res.status = ST_NOT_WHOLE;
                        end else if (32'(pos_eff) + 32'd1 >= 32'(HEADER_BYTES)) begin
                            emit = 1'b1;
                            res  = '{status: ST_OK, failed_lump: '0,
                                     lump_length: '0, entry_size: '0};
                        end else begin
                            emit = 1'b0;
                        end
                    end
                end else if (pos_eff == POS_W'(3)) begin
                    if (word_next != magic_word_reg) begin
                        emit       = 1'b1;
                        res.status = ST_BAD_IDENT;
                    end
                end else if (pos_eff == POS_W'(7)) begin
                    if (word_next != format_version_reg) begin
                        emit       = 1'b1;
                        res.status = ST_BAD_VERSION;
                    end
                end
                // status codes 0..3 carry no lump detail
                if (emit && res.status != ST_NEGATIVE && res.status != ST_PAST_END
                    && res.status != ST_NOT_WHOLE) begin
                    res.failed_lump = '0;
                    res.lump_length = '0;
                    res.entry_size  = '0;
                end
            end
            if (emit) begin
                verdict_next = 1'b1;
            end else begin
                pos_next = pos_eff + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            word_reg    <= '0;
            offset_reg  <= '0;
            rem_reg     <= '0;
            verdict_reg <= 1'b1;
        end else if (adv) begin
            pos_reg     <= pos_next;
            word_reg    <= word_next;
            offset_reg  <= offset_next;
            rem_reg     <= rem_next;
            verdict_reg <= verdict_next;
        end
    end

    // output register, reloaded on every advance, else drained by m_ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (adv) begin
            m_vld_reg <= emit;
        end else if (m_ready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && emit) begin
            m_item_reg <= res;
        end
    end

    // ---------------------------------------------------------------- checks
    // a verdict always leaves the checker idle until the next start
    a_verdict_sets_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && emit) |=> verdict_reg)
        else $error("verdict transfer did not mark header as judged");

    // the walk never runs past the header
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(pos_reg) < 32'(HEADER_BYTES)))
        else $error("byte position beyond header size");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_vld_reg || !in_vld_reg) |-> s_ready)
        else $error("input stalled with free pipeline space");

    // lump detail only comes with the lump failures
    a_detail_only_on_lump: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && (m_item_reg.status == ST_OK || m_item_reg.status == ST_SHORT
            || m_item_reg.status == ST_BAD_IDENT || m_item_reg.status == ST_BAD_VERSION))
        |-> (m_item_reg.failed_lump == '0 && m_item_reg.lump_length == '0
            && m_item_reg.entry_size == '0))
        else $error("lump detail on a non-lump verdict");

endmodule

// ----- tb/bsphv_verdict_checker.sv -----
// ----------------------------------------------------------------------------
// bsphv_verdict_checker
// Watches the byte, verdict and config ports of the BSP header validator,
// keeps its own copy of the header walk and the registers, predicts the
// verdict of each accepted byte and compares every verdict transfer with the
// oldest prediction. Mismatch count and outstanding verdicts go to the top.
// ----------------------------------------------------------------------------
module bsphv_verdict_checker
    import bsphv_pkg::*;
#(
    parameter int LUMP_COUNT = 18
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    output int unsigned fail_count,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR_BYTES = 8 + 8 * LUMP_COUNT;

    // element size per lump, zero for plain byte lumps
    localparam logic [7:0] ELEM_TAB [18] = '{
        8'd0, 8'd72, 8'd16, 8'd36, 8'd48, 8'd4, 8'd4, 8'd40, 8'd12,
        8'd12, 8'd80, 8'd0, 8'd72, 8'd148, 8'd0, 8'd0, 8'd0, 8'd0
    };

    // register copies
    logic [31:0] file_len;
    logic [31:0] magic;
    logic [31:0] version;

    // header walk
    logic [15:0] pos_r;
    logic [31:0] word_r;
    logic [31:0] off_r;
    logic [7:0]  rem_r;
    logic        done_r;

    out_item_t   verdict_q[$];
    int unsigned mismatches;

    function automatic out_item_t make_verdict(input status_t st, input logic [31:0] lump,
                                               input logic [31:0] len, input logic [7:0] es);
        out_item_t v;
        v.status      = st;
        v.failed_lump = lump[4:0];
        v.lump_length = len[30:0];
        v.entry_size  = es;
        return v;
    endfunction

    task automatic predict_verdict(input logic [7:0] b, input logic start,
                                   output logic got, output out_item_t v);
        logic [15:0] pos;
        logic [1:0]  k;
        logic [31:0] rel;
        logic [31:0] lump;
        logic [31:0] lump_byte;
        logic [31:0] part;
        logic [31:0] len;
        logic [7:0]  es;
        got = 1'b0;
        v   = '0;
        if (start) begin
            pos_r  = '0;
            word_r = '0;
            rem_r  = '0;
            done_r = 1'b0;
            if (file_len < HDR_BYTES) begin
                v      = make_verdict(ST_SHORT, '0, '0, '0);
                got    = 1'b1;
                done_r = 1'b1;
                return;
            end
        end else if (done_r) begin
            return;
        end

        pos = pos_r;
        k   = pos[1:0];
        if (k == 2'd0) begin
            word_r = 32'(b);
        end else begin
            word_r = word_r | (32'(b) << (8 * k));
        end

        if (pos >= 16'd8) begin
            rel       = 32'(pos) - 32'd8;
            lump      = rel >> 3;
            lump_byte = rel & 32'd7;
            es        = (lump < 18) ? ELEM_TAB[lump[4:0]] : 8'd0;
            if (lump_byte == 32'd4) begin
                rem_r = '0;
            end
            // running remainder of the length word, byte by byte
            if (lump_byte >= 32'd4 && es != 8'd0) begin
                part  = (32'(b) << (8 * k)) % 32'(es);
                rem_r = 8'((32'(rem_r) + part) % 32'(es));
            end
            if (lump_byte == 32'd3) begin
                off_r = word_r;
            end
            if (lump_byte == 32'd7) begin
                len = word_r;
                if (off_r[31] || len[31]) begin
                    v   = make_verdict(ST_NEGATIVE, lump, len, es);
                    got = 1'b1;
                end else if (({1'b0, off_r} + {1'b0, len}) > {1'b0, file_len}) begin
                    v   = make_verdict(ST_PAST_END, lump, len, es);
                    got = 1'b1;
                end else if (es != 8'd0 && rem_r != 8'd0) begin
                    v   = make_verdict(ST_NOT_WHOLE, lump, len, es);
                    got = 1'b1;
                end else if (32'(pos) + 32'd1 >= HDR_BYTES) begin
                    v   = make_verdict(ST_OK, '0, '0, '0);
                    got = 1'b1;
                end
            end
        end else if (pos == 16'd3) begin
            if (word_r != magic) begin
                v   = make_verdict(ST_BAD_IDENT, '0, '0, '0);
                got = 1'b1;
            end
        end else if (pos == 16'd7) begin
            if (word_r != version) begin
                v   = make_verdict(ST_BAD_VERSION, '0, '0, '0);
                got = 1'b1;
            end
        end

        if (got) begin
            done_r = 1'b1;
        end else begin
            pos_r = pos + 16'd1;
        end
    endtask

    always @(posedge aclk) begin : watch
        logic      got;
        out_item_t v;
        out_item_t exp_v;
        if (!aresetn) begin
            file_len   = '0;
            magic      = MAGIC_RESET;
            version    = VERSION_RESET;
            pos_r      = '0;
            word_r     = '0;
            off_r      = '0;
            rem_r      = '0;
            done_r     = 1'b1;
            mismatches = 0;
            verdict_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FILE_LENGTH:    file_len = cfg_wr_data;
                    REG_MAGIC_WORD:     magic    = cfg_wr_data;
                    REG_FORMAT_VERSION: version  = cfg_wr_data;
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict transfer with none expected: status %0d lump %0d",
                           m_data.status, m_data.failed_lump);
                    mismatches++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (m_data.status !== exp_v.status) begin
                        $error("mismatch on status, expected %0d got %0d",
                               exp_v.status, m_data.status);
                        mismatches++;
                    end
                    if (m_data.failed_lump !== exp_v.failed_lump) begin
                        $error("mismatch on failed_lump, expected %0d got %0d",
                               exp_v.failed_lump, m_data.failed_lump);
                        mismatches++;
                    end
                    if (m_data.lump_length !== exp_v.lump_length) begin
                        $error("mismatch on lump_length, expected %0d got %0d",
                               exp_v.lump_length, m_data.lump_length);
                        mismatches++;
                    end
                    if (m_data.entry_size !== exp_v.entry_size) begin
                        $error("mismatch on entry_size, expected %0d got %0d",
                               exp_v.entry_size, m_data.entry_size);
                        mismatches++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                predict_verdict(s_data.byte_value, s_data.header_start, got, v);
                if (got) begin
                    verdict_q.push_back(v);
                end
            end

            fail_count <= mismatches;
            pending    <= verdict_q.size();
        end
    end

endmodule

// ----- tb/bsp_header_validator_tb.sv -----
// ----------------------------------------------------------------------------
// bsp_header_validator_tb
// Streams BSP headers into the validator byte by byte: a few directed cases,
// then random headers that are mostly well formed with one planted fault,
// plus cut headers and noise, over several register settings and idle mixes.
// A separate checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module bsp_header_validator_tb;
    import bsphv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LUMPS        = 18;
    localparam int HDR_BYTES    = 8 + 8 * LUMPS;
    localparam int SETTLE       = 6;       // pipeline is two deep, give it some slack
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int SEG_COUNT    = 3;
    localparam int SEG_ITEMS    = 150;
    localparam int SEG_HEADERS  = 1;
    localparam int LIMIT_CYCLES = 400000;

    typedef enum int {
        HK_GOOD,
        HK_LUMP_FAULT,
        HK_BAD_IDENT,
        HK_BAD_VERSION,
        HK_CUT,
        HK_NOISE
    } header_kind_t;

    typedef enum int {
        FK_NEG_OFFSET,
        FK_NEG_LENGTH,
        FK_PAST_END,
        FK_NOT_WHOLE
    } fault_kind_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_item_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_item_t   m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = REG_FILE_LENGTH;
    logic [31:0] cfg_wr_data = '0;

    int unsigned fail_count;
    int unsigned pending;

    // idle mix: sender side used only by the stimulus process
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        rx_hold_go  = 1'b0;
    int          hold_left   = 0;

    // register values as last written, used to shape the headers
    logic [31:0] cur_fl;
    logic [31:0] cur_magic;
    logic [31:0] cur_ver;

    // header under construction
    logic [7:0]  hdr      [HDR_BYTES];
    logic [31:0] lump_off [LUMPS];
    logic [31:0] lump_len [LUMPS];

    int          seg_items;
    int          seg_headers;

    bsp_header_validator #(
        .LUMP_COUNT (LUMPS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    bsphv_verdict_checker #(
        .LUMP_COUNT (LUMPS)
    ) u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: random stalls, plus a long hold-off when the stimulus asks for it
    always @(posedge aclk) begin
        if (rx_hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        m_ready <= !rx_hold_go && (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog: a hung handshake ends the run here
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic set_idle(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    // one byte transfer; valid stays up from one byte to the next unless an idle
    // cycle is rolled
    task automatic send_byte(input logic [7:0] b, input logic st);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{byte_value: b, header_start: st};
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and wait until every predicted verdict has been taken,
    // then let the pipeline run empty
    task automatic drain_results();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // writes all three registers back to back, only while the block is idle
    task automatic configure(input logic [31:0] fl, input logic [31:0] mw,
                             input logic [31:0] fv);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_FILE_LENGTH;
        cfg_wr_data <= fl;
        @(posedge aclk);
        cfg_index   <= REG_MAGIC_WORD;
        cfg_wr_data <= mw;
        @(posedge aclk);
        cfg_index   <= REG_FORMAT_VERSION;
        cfg_wr_data <= fv;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_fl    = fl;
        cur_magic = mw;
        cur_ver   = fv;
    endtask

    task automatic put_word(input int at, input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            hdr[at + i] = w[8 * i +: 8];
        end
    endtask

    // a lump that passes: whole entries, inside the file, offsets spread
    // over the full positive range when the file is large
    task automatic pick_lump(input int idx);
        longint fl;
        longint maxlen;
        longint cap;
        longint len;
        longint room;
        int     es;
        fl     = cur_fl;
        es     = elem_size(5'(idx));
        maxlen = (fl < 64'h7FFF_FFFF) ? fl : 64'h7FFF_FFFF;
        cap    = ($urandom_range(0, 3) == 0) ? maxlen : ((maxlen < 2048) ? maxlen : 2048);
        len    = $urandom_range(0, 32'(cap));
        if (es != 0) begin
            len = len - (len % es);
        end
        room = fl - len;
        if (room > 64'h7FFF_FFFF) begin
            room = 64'h7FFF_FFFF;
        end
        lump_off[idx] = $urandom_range(0, 32'(room));
        lump_len[idx] = 32'(len);
    endtask

    task automatic apply_fault(input int idx, input fault_kind_t fk);
        longint fl;
        longint off;
        longint len;
        longint t;
        int     es;
        fl  = cur_fl;
        off = lump_off[idx];
        len = lump_len[idx];
        es  = elem_size(5'(idx));
        case (fk)
            FK_NEG_OFFSET: off = off | 64'h8000_0000;
            FK_NEG_LENGTH: len = len | 64'h8000_0000;
            FK_PAST_END: begin
                // push the offset just past the end, else stretch the length
                t = fl - len + 1 + $urandom_range(0, 7);
                if (t <= 64'h7FFF_FFFF) begin
                    off = t;
                end else begin
                    t = fl - off + 1 + $urandom_range(0, 7);
                    if (t <= 64'h7FFF_FFFF) begin
                        len = t;
                    end
                end
            end
            FK_NOT_WHOLE: begin
                if (es != 0) begin
                    if (len >= es) begin
                        len = len - $urandom_range(1, es - 1);
                    end else begin
                        len = $urandom_range(1, es - 1);
                        off = 0;
                    end
                end
            end
            default: ;
        endcase
        lump_off[idx] = off[31:0];
        lump_len[idx] = len[31:0];
    endtask

    // builds one header and streams it, up to the byte that decides it
    task automatic run_header();
        header_kind_t kind;
        fault_kind_t  fk;
        int           roll;
        int           fault_lump;
        int           stop_at;
        int           cfg_at;
        logic [31:0]  ident;
        logic [31:0]  ver;
        logic [31:0]  new_fl;
        roll = $urandom_range(0, 99);
        if (roll < 30)      kind = HK_GOOD;
        else if (roll < 70) kind = HK_LUMP_FAULT;
        else if (roll < 78) kind = HK_BAD_IDENT;
        else if (roll < 86) kind = HK_BAD_VERSION;
        else if (roll < 96) kind = HK_CUT;
        else                kind = HK_NOISE;

        if (kind == HK_NOISE) begin
            // loose bytes, some of them header starts
            repeat ($urandom_range(1, 12)) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
                seg_items++;
            end
            return;
        end

        for (int i = 0; i < LUMPS; i++) begin
            pick_lump(i);
        end
        ident   = cur_magic;
        ver     = cur_ver;
        stop_at = HDR_BYTES;
        cfg_at  = -1;

        case (kind)
            HK_GOOD: begin
                // now and then rewrite the file length mid-header
                if ($urandom_range(0, 7) == 0) begin
                    cfg_at = $urandom_range(9, HDR_BYTES - 1);
                end
            end
            HK_LUMP_FAULT: begin
                fault_lump = $urandom_range(0, LUMPS - 1);
                fk = fault_kind_t'($urandom_range(0, 3));
                if (fk == FK_NOT_WHOLE) begin
                    while (elem_size(5'(fault_lump)) == 8'd0) begin
                        fault_lump = $urandom_range(0, LUMPS - 1);
                    end
                end
                apply_fault(fault_lump, fk);
                // a second fault on the same lump exercises the check order
                if ($urandom_range(0, 3) == 0) begin
                    apply_fault(fault_lump, fault_kind_t'($urandom_range(0, 3)));
                end
                stop_at = 16 + 8 * fault_lump;
            end
            HK_BAD_IDENT: begin
                ident   = cur_magic ^ (($urandom_range(0, 1) == 1) ?
                          (32'h1 << $urandom_range(0, 31)) : ($urandom | 32'h1));
                stop_at = 4;
            end
            HK_BAD_VERSION: begin
                ver     = cur_ver ^ (($urandom_range(0, 1) == 1) ?
                          (32'h1 << $urandom_range(0, 31)) : ($urandom | 32'h1));
                stop_at = 8;
            end
            HK_CUT: stop_at = $urandom_range(1, HDR_BYTES - 1);
            default: ;
        endcase

        put_word(0, ident);
        put_word(4, ver);
        for (int i = 0; i < LUMPS; i++) begin
            put_word(8 + 8 * i, lump_off[i]);
            put_word(12 + 8 * i, lump_len[i]);
        end

        for (int i = 0; i < stop_at; i++) begin
            if (i == cfg_at) begin
                // header paused with nothing in flight, bound may shrink
                drain_results();
                new_fl = (cur_fl >= HDR_BYTES) ? $urandom_range(HDR_BYTES, cur_fl) : cur_fl;
                configure(new_fl, cur_magic, cur_ver);
            end
            send_byte(hdr[i], i == 0);
            seg_items++;
        end

        if (kind != HK_CUT) begin
            seg_headers++;
            // trailing bytes after a verdict are dropped by the block
            repeat ($urandom_range(0, 2)) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    // fills the block while the receiver is held off: every start byte is a
    // short-file verdict, so the output and input stages back up
    task automatic fill_under_hold();
        drain_results();
        configure(32'd100, cur_magic, cur_ver);
        rx_hold_go <= 1'b1;
        @(posedge aclk);
        rx_hold_go <= 1'b0;
        repeat (24) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        drain_results();
    endtask

    initial begin : stimulus
        logic [31:0] fl;
        logic [31:0] mw;
        logic [31:0] fv;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_idle(13, 62);

        // short file judged on the start byte, later bytes ignored
        configure(32'd0, MAGIC_RESET, VERSION_RESET);
        send_byte(MAGIC_RESET[7:0], 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        // restart in the middle of a header, then a wrong last ident byte
        drain_results();
        configure(32'hFFFF_FFFF, MAGIC_RESET, VERSION_RESET);
        send_byte(MAGIC_RESET[7:0], 1'b1);
        send_byte(MAGIC_RESET[7:0], 1'b1);
        send_byte(MAGIC_RESET[15:8], 1'b0);
        send_byte(MAGIC_RESET[23:16], 1'b0);
        send_byte(8'h51, 1'b0);

        // all-zero ident accepted, version off by the top bit
        drain_results();
        configure(HDR_BYTES, 32'h0, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);

        // random segments: receiver-heavy idling, then sender-heavy, then none
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            case (seg)
                0:       set_idle(13, 62);
                1:       set_idle(62, 13);
                default: set_idle(0, 0);
            endcase
            drain_results();
            if (seg == 1) begin
                fill_under_hold();
            end
            case (seg)
                0: begin
                    fl = $urandom_range(HDR_BYTES, 65536);
                    mw = MAGIC_RESET;
                    fv = VERSION_RESET;
                end
                1: begin
                    fl = 32'hFFFF_FFFF;
                    mw = 32'h0;
                    fv = 32'h0;
                end
                2: begin
                    fl = HDR_BYTES;
                    mw = 32'hFFFF_FFFF;
                    fv = 32'hFFFF_FFFF;
                end
                3: begin
                    fl = 32'h7FFF_FFFF;
                    mw = $urandom;
                    fv = $urandom;
                end
                default: begin
                    fl = ($urandom_range(0, 1) == 1) ? $urandom_range(HDR_BYTES, 1 << 20)
                                                     : $urandom_range(HDR_BYTES, 32'hFFFF_FFFF);
                    mw = ($urandom_range(0, 1) == 1) ? MAGIC_RESET : $urandom;
                    fv = ($urandom_range(0, 1) == 1) ? VERSION_RESET : $urandom;
                end
            endcase
            configure(fl, mw, fv);
            seg_items   = 0;
            seg_headers = 0;
            while (seg_items < SEG_ITEMS || seg_headers < SEG_HEADERS) begin
                run_header();
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bsphv_pkg.sv
hw/rtl/bsp_header_validator.sv
tb/bsphv_verdict_checker.sv
tb/bsp_header_validator_tb.sv
